/* rtl/pcid_pkg.sv */
package pcid_pkg;

  // Field widths of one item and one result.
  localparam int PORT_W  = 2;
  localparam int LEVEL_W = 8;
  localparam int LINE_W  = 3;
  localparam int PIN_W   = 6;
  localparam int LINES   = 8;

  // One memory row per port: the stored levels in the low byte, then the pin
  // of each line, line 0 lowest.
  localparam int ROW_W   = LEVEL_W + LINES * PIN_W;

  // Command codes carried on the input user bit.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_ATTACH = 1'b1;

  typedef enum logic [1:0] {
    KIND_EVENT  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_RESP
  } state_t;

  // One result as it travels from the sequencer to the output register.
  typedef struct packed {
    kind_t            kind;
    logic [PIN_W-1:0] pin;
    logic             obj;
    logic             last;
  } res_t;

endpackage

/* rtl/pcid_ram.sv */
module pcid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pcid_obuf.sv */
module pcid_obuf
  import pcid_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic res_valid,
  output logic res_ready,
  input  res_t res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  res_t data_r;

  // The register takes a new result whenever it is empty or being drained.
  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

endmodule

/* rtl/pcid_seq.sv */
module pcid_seq
  import pcid_pkg::*;
#(
  parameter int NUM_PINS  = 32,
  parameter int NUM_PORTS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input item
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic [PORT_W-1:0]   port,
  input  logic [LEVEL_W-1:0]  value,
  input  logic [LINE_W-1:0]   line_bit,
  input  logic [PIN_W-1:0]    pin,
  input  logic                callback_kind,
  // Row memory
  output logic                ram_we,
  output logic [(NUM_PORTS > 1 ? $clog2(NUM_PORTS) : 1)-1:0] ram_waddr,
  output logic [ROW_W-1:0]    ram_wdata,
  output logic                ram_re,
  output logic [(NUM_PORTS > 1 ? $clog2(NUM_PORTS) : 1)-1:0] ram_raddr,
  input  logic [ROW_W-1:0]    ram_rdata,
  // Result
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res
);

  localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int PW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  state_t                         state_r, state_nxt;
  logic                           cmd_r;
  logic [PORT_W-1:0]              port_r;
  logic [LEVEL_W-1:0]             value_r;
  logic [LINE_W-1:0]              line_r;
  logic [PIN_W-1:0]               pin_r;
  logic                           objk_r;
  kind_t                          kind_r, kind_nxt;
  logic [LINES-1:0]               pend_r, pend_nxt;
  logic [LINES*PIN_W-1:0]         pins_r, pins_nxt;
  logic [NUM_PORTS-1:0]           rv_r, rv_nxt;
  logic [NUM_PORTS-1:0][LINES-1:0] lv_r, lv_nxt;
  logic [NUM_PINS-1:0]            obj_r, obj_nxt;

  logic [AW-1:0]                  addr;
  logic                           port_ok;
  logic                           pin_ok;
  logic [LEVEL_W-1:0]             old_lvl;
  logic [LINES*PIN_W-1:0]         old_pins;
  logic [LINE_W-1:0]              pick;
  logic [PIN_W-1:0]               pick_pin;
  logic [LINES-1:0]               pend_rest;

  assign addr    = AW'(port_r);
  assign port_ok = (32'(port_r) < NUM_PORTS);
  assign pin_ok  = (32'(pin_r) < NUM_PINS);

  // An item is taken only when the previous one has delivered all results.
  assign in_ready  = (state_r == ST_IDLE);
  assign ram_re    = in_valid && in_ready;
  assign ram_raddr = AW'(port);

  // Rows never written read as zero levels; lines never bound are masked by lv_r.
  assign old_lvl  = rv_r[addr] ? ram_rdata[LEVEL_W-1:0] : '0;
  assign old_pins = ram_rdata[ROW_W-1:LEVEL_W];

  // Lowest pending line first.
  always_comb begin
    pick = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        pick = LINE_W'(i);
      end
    end
  end

  assign pick_pin  = pins_r[pick*PIN_W +: PIN_W];
  assign pend_rest = pend_r & (pend_r - LINES'(1));

  // Next state, memory write-back and result.
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    pend_nxt  = pend_r;
    pins_nxt  = pins_r;
    rv_nxt    = rv_r;
    lv_nxt    = lv_r;
    obj_nxt   = obj_r;
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = {old_pins, value_r};
    res_valid = 1'b0;
    res       = '{kind: kind_r, pin: pin_r, obj: 1'b0, last: 1'b1};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end

      ST_READ: begin
        if (cmd_r == CMD_ATTACH) begin
          state_nxt = ST_RESP;
          if (port_ok && pin_ok) begin
            pins_nxt = old_pins;
            pins_nxt[line_r*PIN_W +: PIN_W] = pin_r;
            ram_we    = 1'b1;
            ram_wdata = {pins_nxt, value_r};
            rv_nxt[addr] = 1'b1;
            lv_nxt[addr][line_r] = 1'b1;
            obj_nxt[PW'(pin_r)] = objk_r;
            kind_nxt = KIND_ACCEPT;
          end else begin
            kind_nxt = KIND_REJECT;
          end
        end else if (port_ok) begin
          ram_we       = 1'b1;
          rv_nxt[addr] = 1'b1;
          pins_nxt     = old_pins;
          pend_nxt     = (old_lvl ^ value_r) & lv_r[addr];
          state_nxt    = (pend_nxt != '0) ? ST_SCAN : ST_IDLE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_RESP: begin
        res_valid = 1'b1;
        res.obj   = (kind_r == KIND_ACCEPT) ? objk_r : 1'b0;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        res_valid = 1'b1;
        res.kind  = KIND_EVENT;
        res.pin   = pick_pin;
        res.obj   = obj_r[PW'(pick_pin)];
        res.last  = (pend_rest == '0);
        if (res_ready) begin
          pend_nxt = pend_rest;
          if (pend_rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rv_r    <= '0;
      lv_r    <= '0;
      obj_r   <= '0;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
      lv_r    <= lv_nxt;
      obj_r   <= obj_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Item and row payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= command;
      port_r  <= port;
      value_r <= value;
      line_r  <= line_bit;
      pin_r   <= pin;
      objk_r  <= callback_kind;
    end
    kind_r <= kind_nxt;
    pins_r <= pins_nxt;
  end

  // The row is written back only in the cycle after its read.
  assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> state_r == ST_READ)
    else $error("row write outside the read-modify-write cycle");

  // Scanning always has at least one line left to report.
  assert property (@(posedge clk) disable iff (!rst_n) state_r == ST_SCAN |-> pend_r != '0)
    else $error("event scan with nothing pending");

  // Every event reports a pin below NUM_PINS.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_EVENT |-> 32'(res.pin) < NUM_PINS)
    else $error("event for a pin out of range");

  // A scan starts only from the read cycle of a sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && $past(state_r) != ST_SCAN |-> $past(cmd_r) == CMD_SAMPLE)
    else $error("event scan not started by a sample");

endmodule

/* rtl/pin_change_interrupt_dispatch_core.sv */
// Channel  | Ports                         | Transfer contents
// ---------+-------------------------------+-----------------------------------------
// input    | in_tvalid in_tready in_tdata  | tuser: command; tdata: port, value,
//          | in_tuser                      |   line_bit, pin, callback_kind
// result   | out_tvalid out_tready         | tuser: kind; tlast: last;
//          | out_tdata out_tuser out_tlast |   tdata: event_pin, object_handler
//
// A sample is accepted, its row is read and written back, and its events
// leave one a cycle unless a result stalls; an attach is accepted, its row
// is read and updated when port and pin are valid, and one response leaves.
// Reset is synchronous and active low; it unbinds every line and zeros the
// stored levels at once through valid bits, with no clearing pass.
// A stalled result stops the event scan; the output register lets a new item
// in while the final result of the previous one waits.
module pin_change_interrupt_dispatch_core
  import pcid_pkg::*;
#(
  parameter int NUM_PINS  = 32,
  parameter int NUM_PORTS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // port[1:0], value[9:2], line_bit[12:10], pin[18:13],
                                  // callback_kind[19], zero fill [23:20]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // event_pin[5:0], object_handler[6], zero fill [7]
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast
);

  localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [ROW_W-1:0] ram_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  res_t             out_res;

  // Per-port row: stored levels and the pin of each line.
  pcid_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_PORTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read-modify-write sequencer and event scan.
  pcid_seq #(
    .NUM_PINS  (NUM_PINS),
    .NUM_PORTS (NUM_PORTS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .command       (in_tuser),
    .port          (in_tdata[1:0]),
    .value         (in_tdata[9:2]),
    .line_bit      (in_tdata[12:10]),
    .pin           (in_tdata[18:13]),
    .callback_kind (in_tdata[19]),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // Output register.
  pcid_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {1'b0, out_res.obj, out_res.pin};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule
